FILE: rtl/core/bfsa_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// bfsa_pkg: shared definitions for the best-fit segment allocator
// Widths, operation and status codes, the segment entry layout and the
// write port bundle of the segment table.
// ----------------------------------------------------------------------------
package bfsa_pkg;

   localparam int SEG_SLOTS  = 16;
   localparam int SLOT_W     = $clog2(SEG_SLOTS);
   localparam int COUNT_W    = $clog2(SEG_SLOTS + 1);
   localparam int OWNER_W    = 8;
   localparam int UNITS_W    = 16;
   localparam int OPCODE_W   = 2;
   localparam int STATUS_W   = 3;
   localparam int CSR_ADDR_W = 3;
   localparam int CSR_DATA_W = 32;

   localparam logic [OPCODE_W-1:0] OP_ALLOC   = 2'd0;
   localparam logic [OPCODE_W-1:0] OP_RELEASE = 2'd1;
   localparam logic [OPCODE_W-1:0] OP_COMPACT = 2'd2;

   localparam logic [STATUS_W-1:0] ST_OK        = 3'd0;
   localparam logic [STATUS_W-1:0] ST_NO_FIT    = 3'd1;
   localparam logic [STATUS_W-1:0] ST_NOT_FOUND = 3'd2;
   localparam logic [STATUS_W-1:0] ST_FULL      = 3'd3;
   localparam logic [STATUS_W-1:0] ST_ZERO      = 3'd4;

   // Register index taken from the word address bits of the APB port.
   localparam logic [CSR_ADDR_W-3:0] CSR_IDX_MEM_UNITS = '0;

   typedef struct packed {
      logic [OWNER_W-1:0] owner;
      logic [UNITS_W-1:0] base;
      logic [UNITS_W-1:0] length;
   } seg_entry_type;

   typedef struct packed {
      logic              wr_en;
      logic [SLOT_W-1:0] wr_slot;
      seg_entry_type     wr_data;
   } seg_wr_type;

endpackage
`default_nettype wire

FILE: rtl/core/bfsa_req_if.sv
`default_nettype none
// ----------------------------------------------------------------------------
// bfsa_req_if: request channel
// Valid/ready channel that carries one allocator command word.
// ----------------------------------------------------------------------------
interface bfsa_req_if;
   logic                           valid;
   logic                           ready;
   logic [bfsa_pkg::OPCODE_W-1:0]  opcode;
   logic [bfsa_pkg::OWNER_W-1:0]   owner_id;
   logic [bfsa_pkg::UNITS_W-1:0]   request_units;

   modport source (output valid, output opcode, output owner_id, output request_units,
                   input ready);
   modport sink (input valid, input opcode, input owner_id, input request_units,
                 output ready);
endinterface
`default_nettype wire

FILE: rtl/core/bfsa_rsp_if.sv
`default_nettype none
// ----------------------------------------------------------------------------
// bfsa_rsp_if: response channel
// Valid/ready channel that carries one status and granted base word.
// ----------------------------------------------------------------------------
interface bfsa_rsp_if;
   logic                           valid;
   logic                           ready;
   logic [bfsa_pkg::STATUS_W-1:0]  status;
   logic [bfsa_pkg::UNITS_W-1:0]   granted_base;

   modport source (output valid, output status, output granted_base, input ready);
   modport sink (input valid, input status, input granted_base, output ready);
endinterface
`default_nettype wire

FILE: rtl/core/bfsa_seg_table.sv
`default_nettype none
// ----------------------------------------------------------------------------
// bfsa_seg_table: segment table storage
// Holds owner, base and length of each slot. One write and one registered
// read per cycle: rd_data shows the slot addressed in the previous cycle, as
// it stood before that cycle's write. Contents are undefined until written.
// ----------------------------------------------------------------------------
module bfsa_seg_table (
   input  wire                          clock,
   input  wire bfsa_pkg::seg_wr_type    wr,
   input  wire [bfsa_pkg::SLOT_W-1:0]   rd_slot,
   output bfsa_pkg::seg_entry_type      rd_data
);

   bfsa_pkg::seg_entry_type slots_ff [bfsa_pkg::SEG_SLOTS];
   bfsa_pkg::seg_entry_type rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr.wr_en) begin
         slots_ff[wr.wr_slot] <= wr.wr_data;
      end
      rd_data_ff <= slots_ff[rd_slot];
   end

   assign rd_data = rd_data_ff;

endmodule
`default_nettype wire

FILE: rtl/core/best_fit_segment_allocator.sv
`default_nettype none
// ----------------------------------------------------------------------------
// best_fit_segment_allocator: best-fit contiguous region manager
// Keeps a base-sorted segment table and serves allocate, release and compact
// commands with one shared adder/compare unit stepping one slot per cycle.
// ----------------------------------------------------------------------------
// Allocate scans every gap, shifts the tail up where needed to open a hole,
// inserts the segment and loads the response register; a full table is
// rejected at once. Release finds the owner and shifts the tail down; compact
// rebases every segment in turn. A new word is taken the cycle after the
// response loads, so one command is finished before another is accepted. Reset
// clears the segment count and sets memory_units to 65535; the table needs no clearing.
// ----------------------------------------------------------------------------
module best_fit_segment_allocator (
   input  wire                             clock,
   input  wire                             reset,
   bfsa_req_if.sink                        req,
   bfsa_rsp_if.source                      rsp,
   input  wire                             csr_psel,
   input  wire                             csr_penable,
   input  wire                             csr_pwrite,
   input  wire [bfsa_pkg::CSR_ADDR_W-1:0]  csr_paddr,
   input  wire [bfsa_pkg::CSR_DATA_W-1:0]  csr_pwdata,
   output logic [bfsa_pkg::CSR_DATA_W-1:0] csr_prdata,
   output logic                            csr_pready
);

   localparam int CW = bfsa_pkg::COUNT_W;
   localparam int UW = bfsa_pkg::UNITS_W;
   localparam int SW = bfsa_pkg::SLOT_W;

   typedef enum logic [7:0] {
      S_IDLE     = 8'b0000_0001,
      S_SCAN     = 8'b0000_0010,
      S_SHIFT_UP = 8'b0000_0100,
      S_INSERT   = 8'b0000_1000,
      S_FIND     = 8'b0001_0000,
      S_SHIFT_DN = 8'b0010_0000,
      S_COMPACT  = 8'b0100_0000,
      S_DONE     = 8'b1000_0000
   } state_type;

   state_type                       state_ff, state_in;
   logic [CW-1:0]                   idx_ff, idx_in;
   logic [CW-1:0]                   count_ff, count_in;
   logic [bfsa_pkg::OWNER_W-1:0]    owner_ff, owner_in;
   logic [UW-1:0]                   units_ff, units_in;
   logic [UW:0]                     prev_end_ff, prev_end_in;
   logic                            found_ff, found_in;
   logic [UW-1:0]                   best_gap_ff, best_gap_in;
   logic [CW-1:0]                   best_idx_ff, best_idx_in;
   logic [UW-1:0]                   best_start_ff, best_start_in;
   logic [bfsa_pkg::STATUS_W-1:0]   status_ff, status_in;
   logic [UW-1:0]                   base_ff, base_in;
   logic                            rsp_valid_ff, rsp_valid_in;
   logic [bfsa_pkg::STATUS_W-1:0]   rsp_status_ff, rsp_status_in;
   logic [UW-1:0]                   rsp_base_ff, rsp_base_in;
   logic [UW-1:0]                   mem_units_ff, mem_units_in;

   bfsa_pkg::seg_wr_type            tbl_wr;
   bfsa_pkg::seg_entry_type         tbl_rd;
   logic [CW-1:0]                   rd_idx;
   logic [CW-1:0]                   idx_up;
   logic [CW-1:0]                   idx_dn;

   // Shared unit: one adder and the gap compare.
   logic [UW-1:0]                   add_a;
   logic [UW:0]                     add_sum;
   logic [UW:0]                     gap_start;
   logic [UW:0]                     gap_end;
   logic [UW-1:0]                   gap;
   logic                            gap_fits;

   logic                            csr_sel_units;
   logic                            req_fire;

   bfsa_seg_table u_table (
      .clock   (clock),
      .wr      (tbl_wr),
      .rd_slot (rd_idx[SW-1:0]),
      .rd_data (tbl_rd)
   );

   // Configuration port.
   assign csr_pready    = 1'b1;
   assign csr_sel_units = (csr_paddr[bfsa_pkg::CSR_ADDR_W-1:2] == bfsa_pkg::CSR_IDX_MEM_UNITS);

   always_comb begin
      mem_units_in = mem_units_ff;
      if (csr_psel && csr_penable && csr_pwrite && csr_sel_units) begin
         mem_units_in = csr_pwdata[UW-1:0];
      end
   end

   always_comb begin
      csr_prdata = '0;
      if (csr_sel_units) begin
         csr_prdata = {{(bfsa_pkg::CSR_DATA_W - UW){1'b0}}, mem_units_ff};
      end
   end

   assign req.ready        = (state_ff == S_IDLE);
   assign req_fire         = req.valid && (state_ff == S_IDLE);
   assign rsp.valid        = rsp_valid_ff;
   assign rsp.status       = rsp_status_ff;
   assign rsp.granted_base = rsp_base_ff;

   assign idx_up = idx_ff + CW'(1);
   assign idx_dn = idx_ff - CW'(1);

   // The table read is registered, so the address is formed from the next
   // state and index; tbl_rd then holds the slot that this cycle works on.
   always_comb begin
      case (state_in)
         S_SHIFT_UP: rd_idx = idx_in - CW'(1);
         S_SHIFT_DN: rd_idx = idx_in + CW'(1);
         default:    rd_idx = idx_in;
      endcase
   end

   // During compact prev_end holds the running base of the next segment.
   assign add_a   = (state_ff == S_COMPACT) ? prev_end_ff[UW-1:0] : tbl_rd.base;
   assign add_sum = {1'b0, add_a} + {1'b0, tbl_rd.length};

   assign gap_start = (idx_ff == '0) ? '0 : prev_end_ff;
   assign gap_end   = (idx_ff < count_ff) ? {1'b0, tbl_rd.base} : {1'b0, mem_units_ff};
   assign gap       = (gap_end > gap_start) ? UW'(gap_end - gap_start) : '0;
   assign gap_fits  = (gap >= units_ff) && (!found_ff || (gap < best_gap_ff));

   always_comb begin
      state_in      = state_ff;
      idx_in        = idx_ff;
      count_in      = count_ff;
      owner_in      = owner_ff;
      units_in      = units_ff;
      prev_end_in   = prev_end_ff;
      found_in      = found_ff;
      best_gap_in   = best_gap_ff;
      best_idx_in   = best_idx_ff;
      best_start_in = best_start_ff;
      status_in     = status_ff;
      base_in       = base_ff;
      rsp_valid_in  = rsp_valid_ff;
      rsp_status_in = rsp_status_ff;
      rsp_base_in   = rsp_base_ff;
      tbl_wr        = '0;

      if (rsp.ready) begin
         rsp_valid_in = 1'b0;
      end

      case (state_ff)
         S_IDLE: begin
            if (req_fire) begin
               owner_in    = req.owner_id;
               units_in    = req.request_units;
               idx_in      = '0;
               found_in    = 1'b0;
               prev_end_in = '0;
               base_in     = '0;
               status_in   = bfsa_pkg::ST_OK;
               case (req.opcode)
                  bfsa_pkg::OP_ALLOC: begin
                     if (req.request_units == '0) begin
                        status_in = bfsa_pkg::ST_ZERO;
                        state_in  = S_DONE;
                     end else if (count_ff == CW'(bfsa_pkg::SEG_SLOTS)) begin
                        status_in = bfsa_pkg::ST_FULL;
                        state_in  = S_DONE;
                     end else begin
                        state_in = S_SCAN;
                     end
                  end
                  bfsa_pkg::OP_RELEASE: state_in = S_FIND;
                  bfsa_pkg::OP_COMPACT: state_in = S_COMPACT;
                  default:              state_in = S_DONE;
               endcase
            end
         end

         S_SCAN: begin
            prev_end_in = add_sum;
            if (gap_fits) begin
               found_in      = 1'b1;
               best_gap_in   = gap;
               best_idx_in   = idx_ff;
               best_start_in = gap_start[UW-1:0];
            end
            if (idx_ff == count_ff) begin
               if (!found_in) begin
                  status_in = bfsa_pkg::ST_NO_FIT;
                  state_in  = S_DONE;
               end else if (best_idx_in == count_ff) begin
                  state_in = S_INSERT;
               end else begin
                  idx_in   = count_ff;
                  state_in = S_SHIFT_UP;
               end
            end else begin
               idx_in = idx_up;
            end
         end

         S_SHIFT_UP: begin
            // Open a hole at the chosen slot, moving the tail up by one.
            tbl_wr.wr_en   = 1'b1;
            tbl_wr.wr_slot = idx_ff[SW-1:0];
            tbl_wr.wr_data = tbl_rd;
            idx_in         = idx_dn;
            if (idx_dn == best_idx_ff) begin
               state_in = S_INSERT;
            end
         end

         S_INSERT: begin
            tbl_wr.wr_en          = 1'b1;
            tbl_wr.wr_slot        = best_idx_ff[SW-1:0];
            tbl_wr.wr_data.owner  = owner_ff;
            tbl_wr.wr_data.base   = best_start_ff;
            tbl_wr.wr_data.length = units_ff;
            count_in              = count_ff + CW'(1);
            status_in             = bfsa_pkg::ST_OK;
            base_in               = best_start_ff;
            state_in              = S_DONE;
         end

         S_FIND: begin
            if (idx_ff == count_ff) begin
               status_in = bfsa_pkg::ST_NOT_FOUND;
               state_in  = S_DONE;
            end else if (tbl_rd.owner == owner_ff) begin
               state_in = S_SHIFT_DN;
            end else begin
               idx_in = idx_up;
            end
         end

         S_SHIFT_DN: begin
            if (idx_up < count_ff) begin
               tbl_wr.wr_en   = 1'b1;
               tbl_wr.wr_slot = idx_ff[SW-1:0];
               tbl_wr.wr_data = tbl_rd;
               idx_in         = idx_up;
            end else begin
               count_in  = count_ff - CW'(1);
               status_in = bfsa_pkg::ST_OK;
               state_in  = S_DONE;
            end
         end

         S_COMPACT: begin
            if (idx_ff == count_ff) begin
               status_in = bfsa_pkg::ST_OK;
               state_in  = S_DONE;
            end else begin
               tbl_wr.wr_en          = 1'b1;
               tbl_wr.wr_slot        = idx_ff[SW-1:0];
               tbl_wr.wr_data.owner  = tbl_rd.owner;
               tbl_wr.wr_data.base   = prev_end_ff[UW-1:0];
               tbl_wr.wr_data.length = tbl_rd.length;
               prev_end_in           = add_sum;
               idx_in                = idx_up;
            end
         end

         S_DONE: begin
            // Load the response word once the output register is free.
            if (!rsp_valid_ff || rsp.ready) begin
               rsp_valid_in  = 1'b1;
               rsp_status_in = status_ff;
               rsp_base_in   = base_ff;
               state_in      = S_IDLE;
            end
         end

         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
         mem_units_ff <= '1;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
         mem_units_ff <= mem_units_in;
      end
   end

   always_ff @(posedge clock) begin
      idx_ff        <= idx_in;
      owner_ff      <= owner_in;
      units_ff      <= units_in;
      prev_end_ff   <= prev_end_in;
      found_ff      <= found_in;
      best_gap_ff   <= best_gap_in;
      best_idx_ff   <= best_idx_in;
      best_start_ff <= best_start_in;
      status_ff     <= status_in;
      base_ff       <= base_in;
      rsp_status_ff <= rsp_status_in;
      rsp_base_ff   <= rsp_base_in;
   end

endmodule
`default_nettype wire

FILE: tb/sv/bfsa_tb_pkg.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// bfsa_tb_pkg: scoreboard for the best-fit segment allocator bench
// Keeps a shadow copy of the segment table and the region size, predicts
// the status and granted base for every accepted command word, and checks
// each response word against the oldest outstanding prediction.
// ----------------------------------------------------------------------------
package bfsa_tb_pkg;

   import bfsa_pkg::*;

   typedef struct packed {
      logic [STATUS_W-1:0] status;
      logic [UNITS_W-1:0]  granted_base;
   } alloc_reply_t;

   class allocator_scoreboard;
      logic [UNITS_W-1:0] mem_units;
      logic [OWNER_W-1:0] owner_tab [SEG_SLOTS];
      logic [UNITS_W-1:0] base_tab [SEG_SLOTS];
      logic [UNITS_W-1:0] length_tab [SEG_SLOTS];
      int                 live_count;
      alloc_reply_t       replies_due [$];
      int unsigned        errors;
      int unsigned        commands;
      int unsigned        alloc_by_status [8];
      int unsigned        released;
      int unsigned        not_found;
      int unsigned        compacts;

      function new();
         mem_units = 16'hFFFF;
         live_count = 0;
         errors = 0;
         commands = 0;
         released = 0;
         not_found = 0;
         compacts = 0;
         foreach (alloc_by_status[i]) alloc_by_status[i] = 0;
      endfunction

      task report(input string msg);
         errors++;
         $display("allocator mismatch: %s", msg);
      endtask

      // Best fit over every gap: ahead of the first segment, between
      // neighbors, and from the last segment up to the region size.
      function alloc_reply_t place_segment(input logic [OWNER_W-1:0] who,
                                           input logic [UNITS_W-1:0] units);
         alloc_reply_t   reply;
         logic [UNITS_W:0] lo, hi, gap, best_gap, best_lo;
         int             best_slot;
         bit             found;
         reply.status = ST_OK;
         reply.granted_base = '0;
         found = 1'b0;
         best_slot = 0;
         best_gap = '0;
         best_lo = '0;
         if (units == '0) begin
            reply.status = ST_ZERO;
         end else if (live_count >= SEG_SLOTS) begin
            reply.status = ST_FULL;
         end else begin
            for (int i = 0; i <= live_count; i++) begin
               lo = (i == 0) ? '0 : {1'b0, base_tab[i-1]} + length_tab[i-1];
               hi = (i < live_count) ? {1'b0, base_tab[i]} : {1'b0, mem_units};
               // A region shrunk below the segments leaves a gap of size zero.
               gap = (hi > lo) ? hi - lo : '0;
               if (gap >= units && (!found || gap < best_gap)) begin
                  found = 1'b1;
                  best_gap = gap;
                  best_slot = i;
                  best_lo = lo;
               end
            end
            if (!found) begin
               reply.status = ST_NO_FIT;
            end else begin
               for (int k = live_count; k > best_slot; k--) begin
                  owner_tab[k] = owner_tab[k-1];
                  base_tab[k] = base_tab[k-1];
                  length_tab[k] = length_tab[k-1];
               end
               owner_tab[best_slot] = who;
               base_tab[best_slot] = best_lo[UNITS_W-1:0];
               length_tab[best_slot] = units;
               live_count++;
               reply.granted_base = best_lo[UNITS_W-1:0];
            end
         end
         return reply;
      endfunction

      function logic [STATUS_W-1:0] drop_owner(input logic [OWNER_W-1:0] who);
         for (int i = 0; i < live_count; i++) begin
            if (owner_tab[i] == who) begin
               for (int k = i; k + 1 < live_count; k++) begin
                  owner_tab[k] = owner_tab[k+1];
                  base_tab[k] = base_tab[k+1];
                  length_tab[k] = length_tab[k+1];
               end
               live_count--;
               return ST_OK;
            end
         end
         return ST_NOT_FOUND;
      endfunction

      function void slide_down();
         logic [UNITS_W:0] next_base;
         next_base = '0;
         for (int i = 0; i < live_count; i++) begin
            base_tab[i] = next_base[UNITS_W-1:0];
            next_base = next_base + length_tab[i];
         end
      endfunction

      function void note_command(input logic [OPCODE_W-1:0] op,
                                 input logic [OWNER_W-1:0] who,
                                 input logic [UNITS_W-1:0] units);
         alloc_reply_t reply;
         reply.status = ST_OK;
         reply.granted_base = '0;
         commands++;
         case (op)
            OP_ALLOC: begin
               reply = place_segment(who, units);
               alloc_by_status[reply.status]++;
            end
            OP_RELEASE: begin
               reply.status = drop_owner(who);
               if (reply.status == ST_OK) released++;
               else not_found++;
            end
            OP_COMPACT: begin
               slide_down();
               compacts++;
            end
            default: begin
            end
         endcase
         replies_due.push_back(reply);
      endfunction

      task check_response(input logic [STATUS_W-1:0] status,
                          input logic [UNITS_W-1:0] granted_base);
         alloc_reply_t want;
         if (replies_due.size() == 0) begin
            report($sformatf("response word with nothing outstanding: status %0d base %0d",
                             status, granted_base));
         end else begin
            want = replies_due.pop_front();
            if (status !== want.status)
               report($sformatf("status %0d, expected %0d", status, want.status));
            if (granted_base !== want.granted_base)
               report($sformatf("granted_base %0d, expected %0d",
                                granted_base, want.granted_base));
         end
      endtask
   endclass

endpackage

FILE: tb/sv/best_fit_segment_allocator_tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// best_fit_segment_allocator_tb: self-checking bench for the allocator
// Runs directed allocate, release and compact commands and then random
// phases over several region sizes and handshake idling patterns, checking
// every response word against a shadow table kept by the scoreboard.
// ----------------------------------------------------------------------------
module best_fit_segment_allocator_tb;

   import bfsa_pkg::*;
   import bfsa_tb_pkg::*;

   localparam logic [OPCODE_W-1:0]   OP_UNUSED      = 2'd3;
   localparam logic [CSR_ADDR_W-1:0] MEM_UNITS_ADDR = {CSR_IDX_MEM_UNITS, 2'b00};
   localparam int unsigned           CYCLE_LIMIT    = 1000000;
   localparam int unsigned           DRAIN_CYCLES   = 40;
   localparam int unsigned           LONG_HOLD      = 400;

   logic                  clock = 1'b0;
   logic                  reset;
   logic                  csr_psel;
   logic                  csr_penable;
   logic                  csr_pwrite;
   logic [CSR_ADDR_W-1:0] csr_paddr;
   logic [CSR_DATA_W-1:0] csr_pwdata;
   logic [CSR_DATA_W-1:0] csr_prdata;
   logic                  csr_pready;

   int unsigned sender_idle_pct = 0;
   int unsigned recv_stall_pct = 0;
   int unsigned hold_request = 0;
   int unsigned hold_left = 0;
   int unsigned cycles = 0;

   allocator_scoreboard sb;

   bfsa_req_if req_bus ();
   bfsa_rsp_if rsp_bus ();

   best_fit_segment_allocator DUT (
      .clock       (clock),
      .reset       (reset),
      .req         (req_bus),
      .rsp         (rsp_bus),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready)
   );

   always begin
      #6 clock = 1'b1;
      #6 clock = 1'b0;
   end

   always @(posedge clock) begin
      cycles++;
      if (cycles > CYCLE_LIMIT) begin
         $display("best_fit_segment_allocator_tb: errors");
         $finish;
      end
   end

   // Commands are noted before responses so a word is always predicted first.
   always @(posedge clock) begin
      if (!reset) begin
         if (req_bus.valid && req_bus.ready)
            sb.note_command(req_bus.opcode, req_bus.owner_id, req_bus.request_units);
         if (rsp_bus.valid && rsp_bus.ready)
            sb.check_response(rsp_bus.status, rsp_bus.granted_base);
      end
   end

   // Response side: random stalls, plus a long hold-off when one is requested.
   initial begin
      forever begin
         @(negedge clock);
         if (hold_request != 0) begin
            hold_left = hold_request;
            hold_request = 0;
         end
         if (hold_left != 0) begin
            rsp_bus.ready <= 1'b0;
            hold_left--;
         end else begin
            rsp_bus.ready <= ($urandom_range(99) >= recv_stall_pct);
         end
      end
   end

   // Called at a falling edge; returns at the rising edge that takes the word.
   task automatic drive_word(input logic [OPCODE_W-1:0] op,
                             input logic [OWNER_W-1:0] who,
                             input logic [UNITS_W-1:0] units);
      while ($urandom_range(99) < sender_idle_pct) begin
         req_bus.valid <= 1'b0;
         @(negedge clock);
      end
      req_bus.valid <= 1'b1;
      req_bus.opcode <= op;
      req_bus.owner_id <= who;
      req_bus.request_units <= units;
      @(posedge clock);
      while (!req_bus.ready) @(posedge clock);
   endtask

   task automatic offer(input logic [OPCODE_W-1:0] op,
                        input logic [OWNER_W-1:0] who,
                        input logic [UNITS_W-1:0] units);
      @(negedge clock);
      drive_word(op, who, units);
   endtask

   // Mostly well-formed traffic: releases aim at live owners, sizes are scaled
   // to the region, with a share of zero, oversized and random requests.
   task automatic offer_random();
      logic [OPCODE_W-1:0] op;
      logic [OWNER_W-1:0]  who;
      logic [UNITS_W-1:0]  units;
      int unsigned         pick;
      int unsigned         span;
      @(negedge clock);
      pick = $urandom_range(99);
      if (pick < 50) op = OP_ALLOC;
      else if (pick < 85) op = OP_RELEASE;
      else if (pick < 95) op = OP_COMPACT;
      else op = OP_UNUSED;
      pick = $urandom_range(99);
      if (op == OP_RELEASE && sb.live_count != 0 && pick < 75)
         who = sb.owner_tab[$urandom_range(sb.live_count - 1)];
      else if (pick < 60)
         who = OWNER_W'($urandom_range(15));
      else
         who = OWNER_W'($urandom_range(255));
      span = 32'(sb.mem_units) >> 3;
      if (span == 0) span = 1;
      pick = $urandom_range(99);
      if (pick < 4) units = '0;
      else if (pick < 8) units = UNITS_W'($urandom_range(16'hFFFF));
      else if (pick < 12) units = sb.mem_units;
      else if (pick < 14) units = '1;
      else units = UNITS_W'($urandom_range(span, 1));
      drive_word(op, who, units);
   endtask

   task automatic end_offer();
      @(negedge clock);
      req_bus.valid <= 1'b0;
   endtask

   task automatic drain();
      while (sb.replies_due.size() != 0) @(negedge clock);
   endtask

   // Write the region size, then read it back in a second transfer.
   task automatic set_memory_units(input logic [UNITS_W-1:0] value);
      @(negedge clock);
      csr_psel <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite <= 1'b1;
      csr_paddr <= MEM_UNITS_ADDR;
      csr_pwdata <= {{(CSR_DATA_W-UNITS_W){1'b0}}, value};
      @(negedge clock);
      csr_penable <= 1'b1;
      @(posedge clock);
      while (!csr_pready) @(posedge clock);
      sb.mem_units = value;
      @(negedge clock);
      csr_pwrite <= 1'b0;
      csr_penable <= 1'b0;
      @(negedge clock);
      csr_penable <= 1'b1;
      @(posedge clock);
      while (!csr_pready) @(posedge clock);
      if (csr_prdata[UNITS_W-1:0] !== value)
         sb.report($sformatf("memory_units reads %0d, written %0d",
                             csr_prdata[UNITS_W-1:0], value));
      @(negedge clock);
      csr_psel <= 1'b0;
      csr_penable <= 1'b0;
   endtask

   task automatic run_phase(input logic [UNITS_W-1:0] units_cfg,
                            input int unsigned sidle, input int unsigned rstall,
                            input int unsigned words, input int unsigned pause_at,
                            input int unsigned hold_at);
      set_memory_units(units_cfg);
      sender_idle_pct = sidle;
      recv_stall_pct = rstall;
      for (int unsigned n = 1; n <= words; n++) begin
         if (n == hold_at) hold_request = LONG_HOLD;
         if (n == pause_at) begin
            end_offer();
            drain();
         end
         offer_random();
      end
      end_offer();
      drain();
   endtask

   initial begin
      sb = new();
      reset = 1'b1;
      req_bus.valid = 1'b0;
      req_bus.opcode = OP_ALLOC;
      req_bus.owner_id = '0;
      req_bus.request_units = '0;
      rsp_bus.ready = 1'b0;
      csr_psel = 1'b0;
      csr_penable = 1'b0;
      csr_pwrite = 1'b0;
      csr_paddr = '0;
      csr_pwdata = '0;
      repeat (2) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // Directed: rejects on an empty table, a grant of the whole region, a full
      // table and release of the lowest segment, all at the reset region size.
      offer(OP_ALLOC, 8'h00, 16'h0000);
      offer(OP_RELEASE, 8'hFF, 16'hFFFF);
      offer(OP_UNUSED, 8'hAA, 16'h5555);
      offer(OP_COMPACT, 8'h55, 16'hAAAA);
      offer(OP_ALLOC, 8'h01, 16'hFFFF);
      offer(OP_ALLOC, 8'h02, 16'h0001);
      offer(OP_RELEASE, 8'h01, 16'h0000);
      for (int i = 0; i < SEG_SLOTS; i++)
         offer(OP_ALLOC, 8'(i * 17), 16'h0FFF);
      offer(OP_ALLOC, 8'h5A, 16'h0001);
      offer(OP_RELEASE, 8'h00, 16'h0000);
      offer(OP_COMPACT, 8'h00, 16'h0000);
      end_offer();
      drain();

      // The first phase shrinks the region below the compacted segments.
      run_phase(16'd1000, 81, 0, 130, 0, 0);
      run_phase(16'hFFFF, 0, 0, 170, 60, 100);
      run_phase(16'd300, 0, 81, 130, 0, 0);
      run_phase(16'd0, 14, 14, 40, 0, 0);
      run_phase(16'd1, 0, 0, 40, 0, 0);
      run_phase(16'($urandom_range(65534, 2)), 14, 14, 150, 0, 0);
      run_phase(16'hFFFF, 0, 81, 150, 0, 0);

      repeat (DRAIN_CYCLES) @(posedge clock);
      $display("Ran %0d commands over region sizes 0 to 65535: %0d grants, %0d no fit,",
               sb.commands, sb.alloc_by_status[ST_OK], sb.alloc_by_status[ST_NO_FIT]);
      $display("%0d full, %0d zero size; releases: %0d freed, %0d owner missing;",
               sb.alloc_by_status[ST_FULL], sb.alloc_by_status[ST_ZERO],
               sb.released, sb.not_found);
      $display("%0d compactions; %0d mismatches.", sb.compacts, sb.errors);
      if (sb.errors == 0) begin
         $display("best_fit_segment_allocator_tb: clean");
      end else begin
         $display("best_fit_segment_allocator_tb: errors");
      end
      $finish;
   end

endmodule
